/* rtl/mac_sighting_table_top_defines.svh */
// assertion macros for the mac sighting table
`ifndef MAC_SIGHTING_TABLE_TOP_DEFINES_SVH
`define MAC_SIGHTING_TABLE_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define MST_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mst_pkg.sv */
// shared types and constants of the mac sighting table
package mst_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int MAC_W       = 48;
    localparam int KIND_W      = 2;
    localparam int TIME_W      = 32;
    localparam int DET_W       = 32;
    localparam int CLASS_W     = 2;
    localparam int IVAL_W      = 16;
    localparam int OUT_IDX_W   = 6;
    localparam int NUM_REGS    = 4;
    localparam int REG_IDX_W   = 2;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 48;

    // frame kinds
    localparam logic [KIND_W-1:0] FRAME_BEACON = 2'd0;
    localparam logic [KIND_W-1:0] FRAME_PROBE  = 2'd1;
    localparam logic [KIND_W-1:0] FRAME_DATA   = 2'd2;
    localparam logic [KIND_W-1:0] FRAME_ACTION = 2'd3;

    // device classes
    localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_AP      = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_DEVICE  = 2'd2;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_BEACON = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PROBE  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DATA   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_ACTION = 2'd3;

    // interval reset values
    localparam logic [IVAL_W-1:0] IVAL_RST_DEFAULT = 16'd10;
    localparam logic [IVAL_W-1:0] IVAL_RST_DATA    = 16'd5;

    // one table entry as held in the entry memory
    typedef struct packed {
        logic [MAC_W-1:0]   mac;
        logic [CLASS_W-1:0] cls;
        logic [DET_W-1:0]   count;
        logic [TIME_W-1:0]  last_log;
        logic               logged;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic hit_load;
        logic miss_load;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic scan_end;
        logic out_free;
    } sts_t;

endpackage

/* rtl/mst_ram.sv */
// generic simple dual-port ram with registered read
module mst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/mst_ctrl.sv */
// controller of the mac sighting table: accept, scan, update
module mst_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  mst_pkg::sts_t sts,
    output mst_pkg::cmd_t cmd
);

    import mst_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.hit)
                begin
                    cmd.hit_load = 1'b1;
                    state_next   = ST_UPDATE;
                end
                else if (sts.scan_end)
                begin
                    cmd.miss_load = 1'b1;
                    state_next    = ST_UPDATE;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            ST_UPDATE:
            begin
                // hold until the output register can take the result
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/mst_dp.sv */
// datapath of the mac sighting table: entry memory, scan, update, output register
module mst_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mst_pkg::cmd_t                    cmd,
    output mst_pkg::sts_t                    sts,
    input  logic [mst_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic [mst_pkg::KIND_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mst_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_we,
    input  logic [mst_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [mst_pkg::IVAL_W-1:0]       cfg_data
);

    import mst_pkg::*;

    // item held during its lookup
    logic [MAC_W-1:0]  mac_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [TIME_W-1:0] now_reg;

    // scan state
    logic [CNT_W-1:0]  scan_idx_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              cmp_valid_reg;
    logic [CNT_W-1:0]  used_reg;

    // entry under update
    entry_t            rec_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic              created_reg;
    logic              full_reg;

    logic [IVAL_W-1:0] intervals_reg [NUM_REGS];

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;
    entry_t             upd_entry;
    entry_t             fresh_entry;
    logic               ram_we;

    logic [TIME_W-1:0]  elapsed;
    logic [IVAL_W-1:0]  ival;
    logic               log_it;
    logic [CLASS_W-1:0] cls_new;
    logic [DET_W-1:0]   count_new;
    logic [OUT_TDATA_W-1:0] result;

    assign rd_entry = entry_t'(ram_rdata);

    mst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (upd_entry),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign sts.hit      = cmp_valid_reg && (rd_entry.mac == mac_reg);
    assign sts.scan_end = (scan_idx_reg == used_reg);
    assign sts.out_free = !out_valid_reg || m_tready;

    // entry update
    always_comb
    begin
        ival    = intervals_reg[kind_reg];
        elapsed = now_reg - rec_reg.last_log;
        log_it  = !rec_reg.logged || (elapsed >= {{(TIME_W-IVAL_W){1'b0}}, ival});

        if (kind_reg == FRAME_BEACON)
        begin
            cls_new = CLASS_AP;
        end
        else if (rec_reg.cls == CLASS_UNKNOWN)
        begin
            cls_new = CLASS_DEVICE;
        end
        else
        begin
            cls_new = rec_reg.cls;
        end

        if (rec_reg.count == '1)
        begin
            count_new = rec_reg.count;
        end
        else
        begin
            count_new = rec_reg.count + DET_W'(1);
        end

        upd_entry.mac      = rec_reg.mac;
        upd_entry.cls      = cls_new;
        upd_entry.count    = count_new;
        upd_entry.last_log = log_it ? now_reg : rec_reg.last_log;
        upd_entry.logged   = rec_reg.logged || log_it;

        fresh_entry.mac      = mac_reg;
        fresh_entry.cls      = CLASS_UNKNOWN;
        fresh_entry.count    = '0;
        fresh_entry.last_log = '0;
        fresh_entry.logged   = 1'b0;

        if (full_reg)
        begin
            result = {{(OUT_TDATA_W-OUT_IDX_W-CLASS_W-DET_W-3){1'b0}},
                      1'b1, 1'b0, 1'b0, {DET_W{1'b0}}, {CLASS_W{1'b0}},
                      {OUT_IDX_W{1'b0}}};
        end
        else
        begin
            result = {{(OUT_TDATA_W-OUT_IDX_W-CLASS_W-DET_W-3){1'b0}},
                      1'b0, log_it, created_reg, count_new, cls_new,
                      OUT_IDX_W'(slot_reg)};
        end
    end

    assign ram_we = cmd.commit && !full_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            intervals_reg[REG_BEACON] <= IVAL_RST_DEFAULT;
            intervals_reg[REG_PROBE]  <= IVAL_RST_DEFAULT;
            intervals_reg[REG_DATA]   <= IVAL_RST_DATA;
            intervals_reg[REG_ACTION] <= IVAL_RST_DEFAULT;
        end
        else
        begin
            if (cmd.start)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
            cmp_valid_reg <= cmd.scan;

            if (cmd.commit && created_reg && !full_reg)
            begin
                used_reg <= used_reg + CNT_W'(1);
            end

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BEACON: intervals_reg[REG_BEACON] <= cfg_data;
                    REG_PROBE:  intervals_reg[REG_PROBE]  <= cfg_data;
                    REG_DATA:   intervals_reg[REG_DATA]   <= cfg_data;
                    REG_ACTION: intervals_reg[REG_ACTION] <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mac_reg  <= s_tdata[MAC_W-1:0];
            now_reg  <= s_tdata[MAC_W +: TIME_W];
            kind_reg <= s_tuser;
        end
        if (cmd.scan)
        begin
            cmp_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (cmd.hit_load)
        begin
            rec_reg     <= rd_entry;
            slot_reg    <= cmp_idx_reg;
            created_reg <= 1'b0;
            full_reg    <= 1'b0;
        end
        else if (cmd.miss_load)
        begin
            rec_reg     <= fresh_entry;
            slot_reg    <= used_reg[IDX_W-1:0];
            created_reg <= 1'b1;
            full_reg    <= (used_reg == CNT_W'(TABLE_DEPTH));
        end
        if (cmd.commit)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* rtl/mac_sighting_table_top.sv */
// top level of the mac sighting table
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | tdata: station_mac, now_seconds; tuser: kind
//  m_*     | out       | m_tvalid/m_tready  | tdata: entry_index .. table_full
//  cfg_*   | in        | cfg_we             | cfg_index, cfg_data (four intervals)
//
// a new station or a full table walks every entry in use, while a station found in slot k ends the
// walk there; the result becomes valid in the same cycle as the input reopens: the linear walk
// reads one entry per cycle from the entry ram
// lookup and update are sequential: the next item is taken once the current one is written back
// the result sits in an output register, so a stalled m_tready only holds the update step
// reset clears the fill count and loads the default intervals; the entry ram needs no clearing
`include "mac_sighting_table_top_defines.svh"

module mac_sighting_table_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [47:0] station_mac, [79:48] now_seconds
    input  logic [mst_pkg::IN_TDATA_W-1:0]   s_tdata,
    // [1:0] frame_kind
    input  logic [mst_pkg::KIND_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [5:0] entry_index, [7:6] device_class, [39:8] detections,
    // [40] first_sighting, [41] log_now, [42] table_full, [47:43] zero
    output logic [mst_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_we,
    input  logic [mst_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [mst_pkg::IVAL_W-1:0]       cfg_data
);

    import mst_pkg::*;

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: idle, walk the table, commit the update
    mst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: entry ram, compare, update arithmetic, output register
    mst_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // a match can only be seen while walking, never while idle
    `MST_ASSERT_IMPL(a_hit_only_in_walk, sts.hit, !s_tready, "match seen outside the walk")
    // a committed update always leaves a result waiting
    `MST_ASSERT_NEXT(a_commit_loads_out, cmd.commit, m_tvalid, "commit without result")
    // an accepted item keeps the input closed for the next cycle
    `MST_ASSERT_NEXT(a_accept_closes_in, s_tvalid && s_tready, !s_tready, "input reopened early")

endmodule

/* tb/sv/tb_mac_sighting_table_top.sv */
// self-checking testbench for the mac sighting table top level
module tb_mac_sighting_table_top;
    import mst_pkg::*;

    localparam int RESET_CYCLES     = 7;
    localparam int LONG_HOLD_CYCLES = 400;
    // quiet gap before register writes; the block is already idle after a drain
    localparam int SETTLE_CYCLES    = 8;
    localparam int TAIL_CYCLES      = 80;
    localparam int REPORT_LIMIT     = 10;

    // result layout as it sits on m_tdata, lowest field last
    typedef struct packed {
        logic [4:0]         pad;
        logic               table_full;
        logic               log_now;
        logic               first_sighting;
        logic [DET_W-1:0]   detections;
        logic [CLASS_W-1:0] device_class;
        logic [5:0]         entry_index;
    } sighting_result_t;

    // predicts each sighting and checks results in arrival order
    class sighting_board;
        logic [MAC_W-1:0]   macs      [TABLE_DEPTH];
        logic [CLASS_W-1:0] classes   [TABLE_DEPTH];
        logic [DET_W-1:0]   counts    [TABLE_DEPTH];
        logic [TIME_W-1:0]  last_log  [TABLE_DEPTH];
        bit                 logged    [TABLE_DEPTH];
        int                 used;
        logic [IVAL_W-1:0]  intervals [NUM_REGS];
        sighting_result_t   pending   [$];
        int sightings, created, rejected, logged_count, failures;

        function new();
            used = 0;
            intervals[REG_BEACON] = IVAL_RST_DEFAULT;
            intervals[REG_PROBE]  = IVAL_RST_DEFAULT;
            intervals[REG_DATA]   = IVAL_RST_DATA;
            intervals[REG_ACTION] = IVAL_RST_DEFAULT;
            sightings = 0;
            created = 0;
            rejected = 0;
            logged_count = 0;
            failures = 0;
        endfunction

        function void set_interval(logic [REG_IDX_W-1:0] idx, logic [IVAL_W-1:0] value);
            intervals[idx] = value;
        endfunction

        function void note_sighting(logic [MAC_W-1:0] mac, logic [KIND_W-1:0] kind,
                                    logic [TIME_W-1:0] now);
            sighting_result_t r;
            int slot;
            logic [TIME_W-1:0] elapsed;
            r = '0;
            slot = -1;
            sightings++;
            for (int i = 0; i < used; i++)
            begin
                if (macs[i] == mac)
                begin
                    slot = i;
                    break;
                end
            end
            if (slot < 0)
            begin
                // absent and no room left: refused, nothing stored
                if (used >= TABLE_DEPTH)
                begin
                    r.table_full = 1'b1;
                    rejected++;
                    pending.push_back(r);
                    return;
                end
                slot = used;
                used++;
                macs[slot] = mac;
                classes[slot] = CLASS_UNKNOWN;
                counts[slot] = '0;
                last_log[slot] = '0;
                logged[slot] = 1'b0;
                r.first_sighting = 1'b1;
                created++;
            end
            // beacons mark access points, anything else only promotes an unknown entry
            if (kind == FRAME_BEACON)
                classes[slot] = CLASS_AP;
            else if (classes[slot] == CLASS_UNKNOWN)
                classes[slot] = CLASS_DEVICE;
            if (counts[slot] != '1)
                counts[slot]++;
            // elapsed time wraps modulo 2^32
            elapsed = now - last_log[slot];
            r.log_now = !logged[slot] || (elapsed >= {16'b0, intervals[kind]});
            if (r.log_now)
            begin
                last_log[slot] = now;
                logged[slot] = 1'b1;
                logged_count++;
            end
            r.entry_index = slot[5:0];
            r.device_class = classes[slot];
            r.detections = counts[slot];
            pending.push_back(r);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] word);
            sighting_result_t want, got;
            got = sighting_result_t'(word);
            if (pending.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result %h with nothing outstanding", word);
                return;
            end
            want = pending.pop_front();
            if (got.entry_index != want.entry_index || got.device_class != want.device_class
                || got.detections != want.detections
                || got.first_sighting != want.first_sighting
                || got.log_now != want.log_now || got.table_full != want.table_full
                || got.pad != want.pad)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("mismatch: expected idx %0d class %0d det %0d first %0b log %0b full %0b pad %h",
                             want.entry_index, want.device_class, want.detections,
                             want.first_sighting, want.log_now, want.table_full, want.pad);
                    $display("          got      idx %0d class %0d det %0d first %0b log %0b full %0b pad %h",
                             got.entry_index, got.device_class, got.detections,
                             got.first_sighting, got.log_now, got.table_full, got.pad);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0] s_tuser = FRAME_BEACON;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = REG_BEACON;
    logic [IVAL_W-1:0] cfg_data = '0;

    sighting_board board;

    // idling controls, changed per phase by the stimulus process
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // long hold-off request, taken over by the receiver process
    int hold_request = 0;
    int hold_left = 0;
    int settings_used = 0;

    logic [TIME_W-1:0] clock_s;
    logic [MAC_W-1:0] seen_macs [$];

    mac_sighting_table_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver: checks each accepted result, stalls at random or holds off for a long stretch
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= (rst_n && $urandom_range(99) >= recv_stall_pct);
    end

    // offer one sighting, note it once taken, then maybe leave a gap
    task automatic send_item(input logic [MAC_W-1:0] mac, input logic [KIND_W-1:0] kind,
                             input logic [TIME_W-1:0] now);
        s_tvalid <= 1'b1;
        s_tdata <= {now, mac};
        s_tuser <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_sighting(mac, kind, now);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // sender stops until every outstanding result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [IVAL_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        board.set_interval(idx, value);
    endtask

    // only called with the block idle
    task automatic write_intervals(input logic [IVAL_W-1:0] beacon, input logic [IVAL_W-1:0] probe,
                                   input logic [IVAL_W-1:0] data, input logic [IVAL_W-1:0] action);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_BEACON, beacon);
        write_reg(REG_PROBE, probe);
        write_reg(REG_DATA, data);
        write_reg(REG_ACTION, action);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // mostly known stations with random kinds and a slowly moving clock,
    // plus new stations, near misses of known ones and clock jumps
    task automatic random_sightings(input int count, input bit pause_midway);
        logic [MAC_W-1:0] mac;
        int roll;
        int pick;
        for (int k = 0; k < count; k++)
        begin
            if (pause_midway && k == count / 2)
                drain();
            roll = $urandom_range(99);
            if (seen_macs.size() == 0 || roll < 18)
            begin
                mac[31:0] = $urandom();
                mac[47:32] = 16'($urandom_range(16'hffff));
                seen_macs.push_back(mac);
            end
            else if (roll < 24)
            begin
                // one bit away from a known station
                mac = seen_macs[$urandom_range(seen_macs.size() - 1)]
                      ^ (48'd1 << $urandom_range(MAC_W - 1));
                seen_macs.push_back(mac);
            end
            else
            begin
                // favour the stations that made it into the table
                if (roll < 90 && seen_macs.size() > TABLE_DEPTH)
                    pick = $urandom_range(TABLE_DEPTH - 1);
                else
                    pick = $urandom_range(seen_macs.size() - 1);
                mac = seen_macs[pick];
            end
            if ($urandom_range(99) < 3)
                clock_s = $urandom();
            else
                clock_s = clock_s + $urandom_range(0, 6);
            send_item(mac, KIND_W'($urandom_range(3)), clock_s);
        end
    endtask

    initial
    begin
        #4000000;
        $display("timeout with %0d results outstanding", board.pending.size());
        $display("tb_mac_sighting_table_top: FAIL");
        $finish;
    end

    initial
    begin
        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on the reset intervals: both mac extremes, every kind,
        // class changes, interval boundaries and time wrap
        seen_macs.push_back(48'h0);
        seen_macs.push_back(48'hffff_ffff_ffff);
        seen_macs.push_back(48'h0200_5e10_2233);
        seen_macs.push_back(48'ha5c3_0f81_7e96);
        send_item(48'h0, FRAME_BEACON, 32'd100);
        send_item(48'hffff_ffff_ffff, FRAME_PROBE, 32'd100);
        // probe on an access point keeps the class, too soon to log
        send_item(48'h0, FRAME_PROBE, 32'd105);
        // beacon turns a client device into an access point
        send_item(48'hffff_ffff_ffff, FRAME_BEACON, 32'd106);
        // exactly the interval since the last log
        send_item(48'h0, FRAME_BEACON, 32'd110);
        send_item(48'h0200_5e10_2233, FRAME_DATA, 32'd200);
        send_item(48'h0200_5e10_2233, FRAME_DATA, 32'd204);
        send_item(48'h0200_5e10_2233, FRAME_DATA, 32'd205);
        send_item(48'h0200_5e10_2233, FRAME_ACTION, 32'd214);
        send_item(48'h0200_5e10_2233, FRAME_ACTION, 32'd215);
        // elapsed time across the counter wrap
        send_item(48'ha5c3_0f81_7e96, FRAME_BEACON, 32'hffff_fff8);
        send_item(48'ha5c3_0f81_7e96, FRAME_BEACON, 32'h0000_0001);
        send_item(48'ha5c3_0f81_7e96, FRAME_BEACON, 32'h0000_0002);
        // clock going backwards looks like a huge elapsed time
        send_item(48'ha5c3_0f81_7e96, FRAME_PROBE, 32'h0000_0000);
        send_item(48'hffff_ffff_ffff, FRAME_ACTION, 32'hffff_ffff);
        send_item(48'h0, FRAME_DATA, 32'h8000_0000);

        // start near the top so the clock wraps early
        clock_s = 32'hffff_ff00;

        // zero intervals: everything logs
        write_intervals(16'd0, 16'd0, 16'd0, 16'd0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_sightings(180, 1'b0);

        // largest intervals: only first sightings and clock jumps log
        write_intervals(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_idle_pct = 69;
        recv_stall_pct = 0;
        random_sightings(170, 1'b0);

        // receiver stalls; one long hold-off fills the block and backs up the input
        write_intervals(16'd3, 16'd8, 16'd1, 16'd12);
        send_idle_pct = 0;
        recv_stall_pct = 69;
        hold_request = LONG_HOLD_CYCLES;
        random_sightings(170, 1'b0);

        // short random intervals, both sides idling, one full pause midway
        write_intervals(IVAL_W'($urandom_range(20)), IVAL_W'($urandom_range(20)),
                        IVAL_W'($urandom_range(20)), IVAL_W'($urandom_range(20)));
        send_idle_pct = 28;
        recv_stall_pct = 28;
        random_sightings(170, 1'b1);

        // fully random intervals at full rate
        write_intervals(IVAL_W'($urandom_range(16'hffff)), IVAL_W'($urandom_range(16'hffff)),
                        IVAL_W'($urandom_range(16'hffff)), IVAL_W'($urandom_range(16'hffff)));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_sightings(170, 1'b0);

        write_intervals(16'd1, 16'hfffe, 16'd2, 16'd30);
        send_idle_pct = 69;
        recv_stall_pct = 69;
        random_sightings(170, 1'b0);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        board.failures += board.pending.size();

        $display("covered %0d sightings over %0d interval settings and five idling mixes",
                 board.sightings, settings_used);
        $display("%0d entries created, %0d refused on a full table, %0d logged, %0d failures",
                 board.created, board.rejected, board.logged_count, board.failures);
        if (board.failures == 0)
            $display("tb_mac_sighting_table_top: PASS");
        else
            $display("tb_mac_sighting_table_top: FAIL");
        $finish;
    end

endmodule
